### rtl/core/dwss_pkg.sv
// ----------------------------------------------------------------------------
// dwss_pkg
// Shared types, sizes and address helpers of the diffuse weighted spatial
// spectrum block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwss_pkg;

    localparam int CHANNELS     = 8;
    localparam int ANGLES       = 32;
    localparam int BINS         = 256;

    localparam int STEER_DEPTH  = ANGLES * BINS * CHANNELS;
    localparam int WEIGHT_DEPTH = ANGLES * BINS;
    localparam int COV_DEPTH    = CHANNELS * CHANNELS;

    localparam int STEER_AW     = $clog2(STEER_DEPTH);
    localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);
    localparam int COV_AW       = $clog2(COV_DEPTH);

    localparam int STEER_W      = 48;
    localparam int WEIGHT_W     = 24;
    localparam int COV_W        = 48;

    localparam int CH_W         = $clog2(CHANNELS + 1);
    localparam int CH_IW        = $clog2(CHANNELS);
    localparam int C2_W         = $clog2(CHANNELS * CHANNELS + 1);
    localparam int ANG_W        = $clog2(ANGLES + 1);
    localparam int ANG_IW       = (ANGLES > 1) ? $clog2(ANGLES) : 1;

    localparam int JOB_DEPTH    = 2;
    localparam int JOB_AW       = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W    = $clog2(JOB_DEPTH + 1);
    localparam int RES_DEPTH    = 4;
    localparam int RES_AW       = $clog2(RES_DEPTH);
    localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);

    localparam int CFG_IW       = 2;
    localparam int CFG_DW       = 16;

    // reset values after clamping to the supported range
    localparam logic [CH_W-1:0]  RST_CHANNELS = CH_W'((8 > CHANNELS) ? CHANNELS : 8);
    localparam logic [ANG_W-1:0] RST_ANGLES   = ANG_W'((32 > ANGLES) ? ANGLES : 32);
    localparam logic [15:0]      RST_FLOOR    = 16'd1;

    typedef enum logic [1:0] {
        OP_STEER  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_COV    = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CHANNELS = 2'd0,
        CFG_ANGLES   = 2'd1,
        CFG_FLOOR    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         bin;
        logic [4:0]         angle;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [23:0] re_part;
        logic signed [23:0] im_part;
        logic [31:0]        cov_average;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [4:0]         out_angle;
        logic signed [31:0] spectrum;
        logic               floor_hit;
        logic               out_last;
    } result_t;

    // effective configuration, already clamped
    typedef struct packed {
        logic [CH_W-1:0]  channels;
        logic [ANG_W-1:0] angles;
        logic [15:0]      floor;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  bin;
        logic [31:0] avg;
    } job_t;

    typedef struct packed {
        logic                 steer_we;
        logic [STEER_AW-1:0]  steer_addr;
        logic [STEER_W-1:0]   steer_data;
        logic                 weight_we;
        logic [WEIGHT_AW-1:0] weight_addr;
        logic [WEIGHT_W-1:0]  weight_data;
        logic                 cov_we;
        logic [COV_AW-1:0]    cov_addr;
        logic [COV_W-1:0]     cov_data;
    } ram_wr_t;

    typedef struct packed {
        logic [STEER_AW-1:0]  steer_addr;
        logic [WEIGHT_AW-1:0] weight_addr;
        logic [COV_AW-1:0]    cov_addr;
    } ram_rd_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic [63:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] quotient;
    } div_rsp_t;

    function automatic logic [STEER_AW-1:0] steer_addr(input logic [ANG_IW-1:0] ang,
                                                       input logic [7:0] bin,
                                                       input logic [CH_IW-1:0] ch);
        return (STEER_AW'(ang) * STEER_AW'(BINS) + STEER_AW'(bin)) * STEER_AW'(CHANNELS)
               + STEER_AW'(ch);
    endfunction

    function automatic logic [WEIGHT_AW-1:0] weight_addr(input logic [ANG_IW-1:0] ang,
                                                         input logic [7:0] bin);
        return WEIGHT_AW'(ang) * WEIGHT_AW'(BINS) + WEIGHT_AW'(bin);
    endfunction

    function automatic logic [COV_AW-1:0] cov_addr(input logic [CH_IW-1:0] r,
                                                   input logic [CH_IW-1:0] c);
        return COV_AW'(r) * COV_AW'(CHANNELS) + COV_AW'(c);
    endfunction

endpackage

`default_nettype wire

### rtl/core/dwss_ram.sv
// ----------------------------------------------------------------------------
// dwss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dwss_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/dwss_div.sv
// ----------------------------------------------------------------------------
// dwss_div
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dwss_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  dwss_pkg::div_req_t  req,
    output dwss_pkg::div_rsp_t  rsp
);
    import dwss_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [64:0] rem_sh;

    // one shift and subtract step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[63]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = req.dividend[63];
            quo_next  = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = 64'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // a new division never starts over a running one
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

`default_nettype wire

### rtl/core/dwss_front.sv
// ----------------------------------------------------------------------------
// dwss_front
// Input side: accepts items, writes table and covariance entries, and queues
// a spectrum job on the last covariance element of a bin.
// ----------------------------------------------------------------------------
`default_nettype none

module dwss_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dwss_pkg::item_t   item,
    output dwss_pkg::ram_wr_t wr,
    input  logic              back_busy,
    input  logic              job_pop,
    output logic              job_valid,
    output dwss_pkg::job_t    job
);
    import dwss_pkg::*;

    logic                 accept;
    logic                 idx_ok_steer;
    logic                 idx_ok_weight;
    logic                 idx_ok_cov;
    logic                 job_push;
    job_t                 job_mem [JOB_DEPTH];
    logic [JOB_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [JOB_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] cnt_reg, cnt_next;

    // hold input while a job waits or runs
    assign full   = (cnt_reg != '0) || back_busy;
    assign accept = push && !full;

    // classify the item and range-check its indices
    assign idx_ok_weight = (32'(item.bin) < 32'(BINS)) && (32'(item.angle) < 32'(ANGLES));
    assign idx_ok_steer  = idx_ok_weight && (32'(item.row) < 32'(CHANNELS));
    assign idx_ok_cov    = (32'(item.row) < 32'(CHANNELS)) && (32'(item.col) < 32'(CHANNELS));

    always_comb
    begin
        wr             = '0;
        wr.steer_addr  = steer_addr(ANG_IW'(item.angle), item.bin, CH_IW'(item.row));
        wr.steer_data  = {item.re_part, item.im_part};
        wr.weight_addr = weight_addr(ANG_IW'(item.angle), item.bin);
        wr.weight_data = item.re_part;
        wr.cov_addr    = cov_addr(CH_IW'(item.row), CH_IW'(item.col));
        wr.cov_data    = {item.re_part, item.im_part};
        job_push       = 1'b0;
        if (accept)
        begin
            case (item.opcode)
                OP_STEER:  wr.steer_we  = idx_ok_steer;
                OP_WEIGHT: wr.weight_we = idx_ok_weight;
                OP_COV:
                begin
                    wr.cov_we = idx_ok_cov;
                    job_push  = item.last && (32'(item.bin) < 32'(BINS));
                end
                default: ;
            endcase
        end
    end

    // job queue toward the back end
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (job_push)
        begin
            wr_ptr_next = wr_ptr_reg + JOB_AW'(1);
        end
        if (job_pop)
        begin
            rd_ptr_next = rd_ptr_reg + JOB_AW'(1);
        end
        if (job_push && !job_pop)
        begin
            cnt_next = cnt_reg + JOB_CNT_W'(1);
        end
        else if (!job_push && job_pop)
        begin
            cnt_next = cnt_reg - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_push)
        begin
            job_mem[wr_ptr_reg] <= '{bin: item.bin, avg: item.cov_average};
        end
    end

    assign job_valid = (cnt_reg != '0);
    assign job       = job_mem[rd_ptr_reg];

    // a queued job blocks the next request
    assert property (@(posedge clk) disable iff (!rst_n) job_push |=> full)
        else $error("input not held after job queued");

endmodule

`default_nettype wire

### rtl/core/dwss_back.sv
// ----------------------------------------------------------------------------
// dwss_back
// Spectrum engine: for each active angle, a sequencer drives one 32x32
// multiplier over a^H R a, then the shared divider for the q, ratio and
// final scaling steps, and pushes one saturated result per angle.
// ----------------------------------------------------------------------------
`default_nettype none

module dwss_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dwss_pkg::cfg_t                cfg,
    input  logic                          job_valid,
    input  dwss_pkg::job_t                job,
    output logic                          job_pop,
    output logic                          busy,
    output dwss_pkg::ram_rd_t             rd,
    input  logic [dwss_pkg::STEER_W-1:0]  steer_rdata,
    input  logic [dwss_pkg::WEIGHT_W-1:0] weight_rdata,
    input  logic [dwss_pkg::COV_W-1:0]    cov_rdata,
    output dwss_pkg::div_req_t            div_req,
    input  dwss_pkg::div_rsp_t            div_rsp,
    output logic                          res_push,
    output dwss_pkg::result_t             res,
    input  logic                          res_full
);
    import dwss_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE   = 24'd1,
        S_WREQ   = 24'd2,
        S_WCAP   = 24'd4,
        S_AREQ   = 24'd8,
        S_ACAP   = 24'd16,
        S_CREQ   = 24'd32,
        S_CCAP   = 24'd64,
        S_M0     = 24'd128,
        S_M1     = 24'd256,
        S_M2     = 24'd512,
        S_M3     = 24'd1024,
        S_T0     = 24'd2048,
        S_T1     = 24'd4096,
        S_FLUSH  = 24'd8192,
        S_QSTART = 24'd16384,
        S_QWAIT  = 24'd32768,
        S_DCALC  = 24'd65536,
        S_NUM    = 24'd131072,
        S_NWAIT  = 24'd262144,
        S_RSTART = 24'd524288,
        S_RWAIT  = 24'd1048576,
        S_SSTART = 24'd2097152,
        S_SWAIT  = 24'd4194304,
        S_EMIT   = 24'd8388608
    } state_t;

    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_TA_ADD = 3'd1,
        ACC_TA_SUB = 3'd2,
        ACC_TB_ADD = 3'd3,
        ACC_FC_ADD = 3'd4,
        ACC_NUM    = 3'd5
    } acc_t;

    state_t              state_reg, state_next;
    acc_t                acc_reg, acc_next;
    logic [ANG_IW-1:0]   n_reg, n_next;
    logic [CH_IW-1:0]    i_reg, i_next;
    logic [CH_IW-1:0]    j_reg, j_next;
    logic [7:0]          bin_reg, bin_next;
    logic [31:0]         avg_reg, avg_next;
    logic signed [23:0]  b_reg, b_next;
    logic [COV_W-1:0]    r_reg, r_next;
    logic [STEER_W-1:0]  a_reg [CHANNELS];
    logic [STEER_W-1:0]  a_next [CHANNELS];
    logic signed [63:0]  ta_reg, ta_next;
    logic signed [63:0]  tb_reg, tb_next;
    logic signed [63:0]  fc_reg, fc_next;
    logic signed [63:0]  prod_reg;
    logic signed [31:0]  q_reg, q_next;
    logic signed [34:0]  d_reg, d_next;
    logic                hit_reg, hit_next;
    logic signed [63:0]  num_reg, num_next;
    logic signed [63:0]  rb_reg, rb_next;
    result_t             res_reg, res_next;

    logic [C2_W-1:0]     c2;
    logic [CH_IW-1:0]    sel_idx;
    logic [STEER_W-1:0]  a_sel;
    logic signed [23:0]  sa, sb, ra, rb;
    logic signed [31:0]  ta_tr, tb_tr;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [34:0]  d_raw, fl_s;
    logic signed [31:0]  fac;
    logic                j_last, i_last, n_last;

    assign c2 = C2_W'(cfg.channels) * C2_W'(cfg.channels);

    // one steering read port, shared between column and row index
    assign sel_idx = (state_reg == S_T0 || state_reg == S_T1) ? i_reg : j_reg;
    assign a_sel   = a_reg[sel_idx];
    assign sa      = a_sel[47:24];
    assign sb      = a_sel[23:0];
    assign ra      = r_reg[47:24];
    assign rb      = r_reg[23:0];

    // truncate row sums toward zero by 2^21
    assign ta_tr = 32'((ta_reg + (ta_reg[63] ? 64'sd2097151 : 64'sd0)) >>> 21);
    assign tb_tr = 32'((tb_reg + (tb_reg[63] ? 64'sd2097151 : 64'sd0)) >>> 21);

    assign d_raw = $signed({3'b000, avg_reg}) - 35'(q_reg);
    assign fl_s  = $signed({19'd0, cfg.floor});
    assign fac   = $signed(32'(c2) << 15) - 32'(b_reg);

    assign j_last = (CH_W'(j_reg) == cfg.channels - CH_W'(1));
    assign i_last = (CH_W'(i_reg) == cfg.channels - CH_W'(1));
    assign n_last = (ANG_W'(n_reg) == cfg.angles - ANG_W'(1));

    assign mul_p = mul_a * mul_b;

    // table and covariance read addresses
    always_comb
    begin
        rd.steer_addr  = steer_addr(n_reg, bin_reg, j_reg);
        rd.weight_addr = weight_addr(n_reg, bin_reg);
        rd.cov_addr    = cov_addr(i_reg, j_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = ACC_NONE;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        bin_next   = bin_reg;
        avg_next   = avg_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        fc_next    = fc_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        hit_next   = hit_reg;
        num_next   = num_reg;
        rb_next    = rb_reg;
        res_next   = res_reg;
        mul_a      = 32'(ra);
        mul_b      = 32'(sa);
        job_pop    = 1'b0;
        res_push   = 1'b0;
        div_req    = '{start: 1'b0, dividend: fc_reg, divisor: 64'(c2) << 21};

        // land the product of the previous cycle
        case (acc_reg)
            ACC_TA_ADD: ta_next  = ta_reg + prod_reg;
            ACC_TA_SUB: ta_next  = ta_reg - prod_reg;
            ACC_TB_ADD: tb_next  = tb_reg + prod_reg;
            ACC_FC_ADD: fc_next  = fc_reg + prod_reg;
            ACC_NUM:    num_next = prod_reg;
            default: ;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    bin_next   = job.bin;
                    avg_next   = job.avg;
                    n_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_WREQ;
                end
            end
            S_WREQ: state_next = S_WCAP;
            S_WCAP:
            begin
                b_next     = weight_rdata;
                j_next     = '0;
                state_next = S_AREQ;
            end
            S_AREQ: state_next = S_ACAP;
            S_ACAP:
            begin
                a_next[j_reg] = steer_rdata;
                if (j_last)
                begin
                    j_next     = '0;
                    i_next     = '0;
                    ta_next    = '0;
                    tb_next    = '0;
                    fc_next    = '0;
                    state_next = S_CREQ;
                end
                else
                begin
                    j_next     = j_reg + CH_IW'(1);
                    state_next = S_AREQ;
                end
            end
            S_CREQ: state_next = S_CCAP;
            S_CCAP:
            begin
                r_next     = cov_rdata;
                state_next = S_M0;
            end
            S_M0:
            begin
                mul_a      = 32'(ra);
                mul_b      = 32'(sa);
                acc_next   = ACC_TA_ADD;
                state_next = S_M1;
            end
            S_M1:
            begin
                mul_a      = 32'(rb);
                mul_b      = 32'(sb);
                acc_next   = ACC_TA_SUB;
                state_next = S_M2;
            end
            S_M2:
            begin
                mul_a      = 32'(ra);
                mul_b      = 32'(sb);
                acc_next   = ACC_TB_ADD;
                state_next = S_M3;
            end
            S_M3:
            begin
                mul_a    = 32'(rb);
                mul_b    = 32'(sa);
                acc_next = ACC_TB_ADD;
                if (j_last)
                begin
                    state_next = S_T0;
                end
                else
                begin
                    j_next     = j_reg + CH_IW'(1);
                    state_next = S_CREQ;
                end
            end
            S_T0:
            begin
                mul_a      = 32'(sa);
                mul_b      = ta_tr;
                acc_next   = ACC_FC_ADD;
                state_next = S_T1;
            end
            S_T1:
            begin
                mul_a    = 32'(sb);
                mul_b    = tb_tr;
                acc_next = ACC_FC_ADD;
                ta_next  = '0;
                tb_next  = '0;
                j_next   = '0;
                if (i_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    i_next     = i_reg + CH_IW'(1);
                    state_next = S_CREQ;
                end
            end
            S_FLUSH: state_next = S_QSTART;
            S_QSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient[31:0];
                    state_next = S_DCALC;
                end
            end
            S_DCALC:
            begin
                hit_next   = (d_raw < fl_s);
                d_next     = (d_raw < fl_s) ? fl_s : d_raw;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                mul_a      = fac;
                mul_b      = q_reg;
                acc_next   = ACC_NUM;
                state_next = S_NWAIT;
            end
            S_NWAIT: state_next = S_RSTART;
            S_RSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = 64'($unsigned(d_reg));
                state_next       = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    rb_next    = div_rsp.quotient - 64'(b_reg);
                    state_next = S_SSTART;
                end
            end
            S_SSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rb_reg;
                div_req.divisor  = 64'(c2);
                state_next       = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next.out_angle = 5'(n_reg);
                    res_next.floor_hit = hit_reg;
                    res_next.out_last  = n_last;
                    if (div_rsp.quotient > 64'sd2147483647)
                    begin
                        res_next.spectrum = 32'sh7fffffff;
                    end
                    else if (div_rsp.quotient < -64'sd2147483648)
                    begin
                        res_next.spectrum = 32'sh80000000;
                    end
                    else
                    begin
                        res_next.spectrum = div_rsp.quotient[31:0];
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (n_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next     = n_reg + ANG_IW'(1);
                        state_next = S_WREQ;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= ACC_NONE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        avg_reg  <= avg_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        a_reg    <= a_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        fc_reg   <= fc_next;
        prod_reg <= mul_p;
        q_reg    <= q_next;
        d_reg    <= d_next;
        hit_reg  <= hit_next;
        num_reg  <= num_next;
        rb_reg   <= rb_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

    // a stalled result waits in place
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_full) |=> (state_reg == S_EMIT))
        else $error("result dropped while output full");

endmodule

`default_nettype wire

### rtl/core/diffuse_weighted_spatial_spectrum.sv
// ----------------------------------------------------------------------------
// diffuse_weighted_spatial_spectrum
// Steered-response spatial spectrum with diffuse-noise weighting.
// ----------------------------------------------------------------------------
// Input channel (push/full) takes table loads (steering element, weight B)
// and covariance elements of one bin. Loads and non-final covariance
// elements give no result.
// The covariance element flagged last starts a run over the active angles;
// one result per angle leaves in angle order on the result channel
// (empty/pop), out_last marking the final angle.
// Per angle the run walks a^H R a over the active channels on the single
// multiplier, then makes three divisions on the shared 64-bit divider.
// full stays high from the last element until the run has handed its final
// result to the output queue; a four-entry result queue lets the engine run
// ahead of a slow receiver, and it stalls only when that queue is full.
// Configuration writes (cfg_valid/cfg_ready) are always ready and are meant
// for idle periods. Reset empties both queues, stops the engine and restores
// the default configuration; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module diffuse_weighted_spatial_spectrum
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  dwss_pkg::item_t               item,
    output logic                          empty,
    input  logic                          pop,
    output dwss_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dwss_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [dwss_pkg::CFG_DW-1:0]   cfg_data
);
    import dwss_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    ram_wr_t              wr;
    ram_rd_t              rd;
    logic [STEER_W-1:0]   steer_rdata;
    logic [WEIGHT_W-1:0]  weight_rdata;
    logic [COV_W-1:0]     cov_rdata;
    logic                 back_busy;
    logic                 job_pop;
    logic                 job_valid;
    job_t                 job;
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic                 res_push;
    result_t              res_in;
    logic                 res_full;
    result_t              res_mem [RES_DEPTH];
    logic [RES_AW-1:0]    res_wr_reg, res_wr_next;
    logic [RES_AW-1:0]    res_rd_reg, res_rd_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 res_pop;

    // configuration, stored already clamped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHANNELS:
                begin
                    if (cfg_data[3:0] == 4'd0)
                        cfg_next.channels = CH_W'(1);
                    else if (32'(cfg_data[3:0]) > 32'(CHANNELS))
                        cfg_next.channels = CH_W'(CHANNELS);
                    else
                        cfg_next.channels = CH_W'(cfg_data[3:0]);
                end
                CFG_ANGLES:
                begin
                    if (cfg_data[5:0] == 6'd0)
                        cfg_next.angles = ANG_W'(1);
                    else if (32'(cfg_data[5:0]) > 32'(ANGLES))
                        cfg_next.angles = ANG_W'(ANGLES);
                    else
                        cfg_next.angles = ANG_W'(cfg_data[5:0]);
                end
                CFG_FLOOR:
                begin
                    cfg_next.floor = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{channels: RST_CHANNELS, angles: RST_ANGLES, floor: RST_FLOOR};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dwss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .wr        (wr),
        .back_busy (back_busy),
        .job_pop   (job_pop),
        .job_valid (job_valid),
        .job       (job)
    );

    dwss_ram #(.WIDTH(STEER_W), .DEPTH(STEER_DEPTH)) u_steer_ram
    (
        .clk   (clk),
        .we    (wr.steer_we),
        .waddr (wr.steer_addr),
        .wdata (wr.steer_data),
        .raddr (rd.steer_addr),
        .rdata (steer_rdata)
    );

    dwss_ram #(.WIDTH(WEIGHT_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram
    (
        .clk   (clk),
        .we    (wr.weight_we),
        .waddr (wr.weight_addr),
        .wdata (wr.weight_data),
        .raddr (rd.weight_addr),
        .rdata (weight_rdata)
    );

    dwss_ram #(.WIDTH(COV_W), .DEPTH(COV_DEPTH)) u_cov_ram
    (
        .clk   (clk),
        .we    (wr.cov_we),
        .waddr (wr.cov_addr),
        .wdata (wr.cov_data),
        .raddr (rd.cov_addr),
        .rdata (cov_rdata)
    );

    dwss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dwss_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .busy         (back_busy),
        .rd           (rd),
        .steer_rdata  (steer_rdata),
        .weight_rdata (weight_rdata),
        .cov_rdata    (cov_rdata),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .res_push     (res_push),
        .res          (res_in),
        .res_full     (res_full)
    );

    // result queue toward the receiver
    assign res_full = (res_cnt_reg == RES_CNT_W'(RES_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign res_pop  = pop && !empty;
    assign result   = res_mem[res_rd_reg];

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (res_push)
        begin
            res_wr_next = res_wr_reg + RES_AW'(1);
        end
        if (res_pop)
        begin
            res_rd_next = res_rd_reg + RES_AW'(1);
        end
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
        end
        else if (!res_push && res_pop)
        begin
            res_cnt_next = res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem[res_wr_reg] <= res_in;
        end
    end

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire

### test/tb.sv
// ============================================================================
// Spatial spectrum block testbench
// Loads steering, weight and covariance data through the request queue,
// predicts every per-angle spectrum result in a scoreboard and compares the
// results in order while both sides idle at random.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwss_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int TOTAL_ITEMS = 400;

    // preloaded bin: every last element uses this one
    localparam logic [7:0] RUN_BIN = 8'd255;

    // ------------------------------------------------------------------------
    // Scoreboard: spectrum predictor and queue of pending spectra
    // ------------------------------------------------------------------------
    class spectrum_scoreboard;
        int          steer_re [STEER_DEPTH];
        int          steer_im [STEER_DEPTH];
        int          weight_b [WEIGHT_DEPTH];
        int          cov_re   [COV_DEPTH];
        int          cov_im   [COV_DEPTH];
        logic [3:0]  chan_reg  = 4'd8;
        logic [5:0]  angle_reg = 6'd32;
        logic [15:0] floor_reg = 16'd1;
        result_t     pending_q[$];
        int          mismatches = 0;

        function void write_reg(cfg_idx_t idx, logic [15:0] data);
            case (idx)
                CFG_CHANNELS: chan_reg  = data[3:0];
                CFG_ANGLES:   angle_reg = data[5:0];
                CFG_FLOOR:    floor_reg = data;
                default:      ;
            endcase
        endfunction

        function int eff_chan();
            if (chan_reg == 0) return 1;
            if (int'(chan_reg) > CHANNELS) return CHANNELS;
            return int'(chan_reg);
        endfunction

        function int eff_angles();
            if (angle_reg == 0) return 1;
            if (int'(angle_reg) > ANGLES) return ANGLES;
            return int'(angle_reg);
        endfunction

        // note an accepted request and queue the spectra it causes
        function void note_item(item_t it);
            int      base, cidx;
            int      c, c2, na;
            longint  fc, ta, tb_acc, q, d, fl, b, r, s;
            result_t res;
            case (it.opcode)
                OP_STEER:
                begin
                    base = (int'(it.angle) * BINS + int'(it.bin)) * CHANNELS + int'(it.row);
                    steer_re[base] = int'(it.re_part);
                    steer_im[base] = int'(it.im_part);
                end
                OP_WEIGHT: weight_b[int'(it.angle) * BINS + int'(it.bin)] = int'(it.re_part);
                OP_COV:
                begin
                    cidx = int'(it.row) * CHANNELS + int'(it.col);
                    cov_re[cidx] = int'(it.re_part);
                    cov_im[cidx] = int'(it.im_part);
                    if (it.last)
                    begin
                        c  = eff_chan();
                        c2 = c * c;
                        na = eff_angles();
                        fl = (floor_reg == 0) ? 1 : longint'(floor_reg);
                        for (int n = 0; n < na; n++)
                        begin
                            base = (n * BINS + int'(it.bin)) * CHANNELS;
                            fc = 0;
                            for (int i = 0; i < c; i++)
                            begin
                                ta = 0;
                                tb_acc = 0;
                                for (int j = 0; j < c; j++)
                                begin
                                    ta += longint'(cov_re[i*CHANNELS+j]) * steer_re[base+j]
                                        - longint'(cov_im[i*CHANNELS+j]) * steer_im[base+j];
                                    tb_acc += longint'(cov_re[i*CHANNELS+j]) * steer_im[base+j]
                                        + longint'(cov_im[i*CHANNELS+j]) * steer_re[base+j];
                                end
                                ta = ta / (64'sd1 << 21);
                                tb_acc = tb_acc / (64'sd1 << 21);
                                fc += longint'(steer_re[base+i]) * ta
                                    + longint'(steer_im[base+i]) * tb_acc;
                            end
                            q = fc / (longint'(c2) * (64'sd1 << 21));
                            d = longint'(it.cov_average) - q;
                            res.floor_hit = (d < fl);
                            if (d < fl) d = fl;
                            b = weight_b[n * BINS + int'(it.bin)];
                            r = (longint'(c2) * 32768 - b) * q / d;
                            s = (r - b) / c2;
                            if (s > 64'sd2147483647) s = 64'sd2147483647;
                            if (s < -64'sd2147483648) s = -64'sd2147483648;
                            res.out_angle = n[4:0];
                            res.spectrum  = s[31:0];
                            res.out_last  = (n == na - 1);
                            pending_q.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one accepted spectrum with the oldest pending one
        function void check_result(result_t got);
            result_t exp_r;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: angle %0d spectrum %0d", got.out_angle,
                             got.spectrum);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.out_angle != exp_r.out_angle || got.spectrum != exp_r.spectrum ||
                got.floor_hit != exp_r.floor_hit || got.out_last != exp_r.out_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp a%0d s%0d f%0b l%0b, got a%0d s%0d f%0b l%0b",
                             exp_r.out_angle, exp_r.spectrum, exp_r.floor_hit,
                             exp_r.out_last, got.out_angle, got.spectrum, got.floor_hit,
                             got.out_last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    item_t               in_item;
    logic                empty;
    logic                pop;
    result_t             out_res;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    spectrum_scoreboard  sb;
    int                  burst_left;
    int                  idle_cycles;
    int                  items_sent;

    diffuse_weighted_spatial_spectrum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (in_item),
        .empty     (empty),
        .pop       (pop),
        .result    (out_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on alternating random run and stall lengths
    // ------------------------------------------------------------------------
    int pop_run;
    int pop_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_run   <= 0;
            pop_stall <= 0;
        end
        else if (pop_stall > 0)
        begin
            pop       <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else if (pop_run > 0)
        begin
            pop     <= 1'b1;
            pop_run <= pop_run - 1;
        end
        else
        begin
            pop       <= 1'b1;
            pop_run   <= ($urandom_range(0, 3) == 0) ? 200 : int'($urandom_range(1, 12));
            pop_stall <= int'($urandom_range(0, 9));
        end
    end

    // check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(out_res);
    end

    // watchdog on cycles with no accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(item_t it);
        int gap;
        if (burst_left <= 0)
        begin
            gap = int'($urandom_range(0, 6));
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : int'($urandom_range(1, 10));
        end
        burst_left--;
        in_item <= it;
        push    <= 1'b1;
        do @(posedge clk); while (full);
        sb.note_item(it);
        items_sent++;
    endtask

    // hold off until every pending spectrum has arrived and the engine is quiet
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [15:0] ch, logic [15:0] ang, logic [15:0] fl);
        drain();
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_ANGLES, ang);
        write_reg(CFG_FLOOR, fl);
    endtask

    function automatic item_t rand_item(opcode_t op);
        item_t it;
        it.opcode      = op;
        it.bin         = 8'($urandom_range(0, 255));
        it.angle       = 5'($urandom_range(0, 31));
        it.row         = 3'($urandom_range(0, 7));
        it.col         = 3'($urandom_range(0, 7));
        it.re_part     = 24'($urandom);
        it.im_part     = 24'($urandom);
        it.cov_average = $urandom;
        it.last        = (op == OP_COV) ? 1'b0 : 1'($urandom_range(0, 1));
        return it;
    endfunction

    // send a full covariance matrix of the active size, last on the final element
    task automatic send_matrix(logic [7:0] bin, logic [31:0] avg);
        item_t it;
        int    c;
        c = sb.eff_chan();
        for (int i = 0; i < c; i++)
            for (int j = 0; j < c; j++)
            begin
                it = rand_item(OP_COV);
                it.bin = bin;
                it.row = 3'(i);
                it.col = 3'(j);
                it.cov_average = avg;
                it.last = (i == c - 1) && (j == c - 1);
                send_item(it);
            end
    endtask

    // approximate engine cycles of one run under the current setting
    function automatic int run_cost();
        int c;
        c = sb.eff_chan();
        return sb.eff_angles() * (2 + 2 * c + c * (6 * c + 2) + 203);
    endfunction

    initial
    begin
        item_t       it;
        int          runs_left;
        int          pick;
        logic [15:0] ph_ch, ph_ang, ph_fl;

        sb          = new();
        burst_left  = 0;
        idle_cycles = 0;
        items_sent  = 0;
        rst_n       = 1'b0;
        push        = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CHANNELS;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // preload the tables of the run bin
        for (int a = 0; a < ANGLES; a++)
        begin
            it = rand_item(OP_WEIGHT);
            it.bin = RUN_BIN;
            it.angle = 5'(a);
            send_item(it);
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                it = rand_item(OP_STEER);
                it.bin = RUN_BIN;
                it.angle = 5'(a);
                it.row = 3'(ch);
                send_item(it);
            end
        end

        // directed: weight extremes, ignored opcode, last flag on loads
        it = rand_item(OP_WEIGHT);
        it.bin = RUN_BIN; it.angle = 5'd0; it.re_part = 24'sh7FFFFF; it.last = 1'b1;
        send_item(it);
        it.angle = 5'd1; it.re_part = 24'sh800000;
        send_item(it);
        it = rand_item(OP_STEER);
        it.bin = RUN_BIN; it.angle = 5'd0; it.row = 3'd7; it.last = 1'b1;
        it.re_part = 24'sh7FFFFF; it.im_part = 24'sh800000;
        send_item(it);
        it = rand_item(OP_COV);
        it.opcode = 2'd3; it.last = 1'b1;
        send_item(it);

        // directed run at reset settings: fill the whole covariance buffer,
        // extreme values on the final element
        for (int r = 0; r < CHANNELS; r++)
            for (int cc = 0; cc < CHANNELS; cc++)
            begin
                it = rand_item(OP_COV);
                it.bin = RUN_BIN;
                it.row = 3'(r);
                it.col = 3'(cc);
                if (r == CHANNELS - 1 && cc == CHANNELS - 1)
                begin
                    it.re_part = 24'sh7FFFFF; it.im_part = 24'sh800000;
                    it.cov_average = 32'hFFFFFFFF; it.last = 1'b1;
                end
                send_item(it);
            end

        // directed runs: zero register values, then wide writes whose upper
        // bits are dropped, then a small setting
        set_config(16'd0, 16'd0, 16'd0);
        it.re_part = 24'sh800000; it.cov_average = 32'd0; it.row = 3'd0; it.col = 3'd0;
        send_item(it);
        set_config(16'hFFF2, 16'hFFC2, 16'hFFFF);
        send_matrix(RUN_BIN, 32'd0);
        set_config(16'd2, 16'd3, 16'd1);
        send_matrix(RUN_BIN, 32'hFFFFFFFF);

        // random phases of well-formed bins mixed with noise
        for (int ph = 0; items_sent < TOTAL_ITEMS; ph++)
        begin
            case (ph % 6)
                0: begin ph_ch = 16'd8;  ph_ang = 16'd32; ph_fl = 16'd1;     end
                1: begin ph_ch = 16'd1;  ph_ang = 16'd1;  ph_fl = 16'd65535; end
                2:
                begin
                    ph_ch  = 16'($urandom);
                    ph_ang = 16'($urandom);
                    ph_fl  = 16'($urandom);
                end
                default:
                begin
                    ph_ch  = 16'($urandom_range(1, 4));
                    ph_ang = 16'($urandom_range(1, 8));
                    ph_fl  = $urandom_range(1, 3) == 1 ? 16'($urandom)
                                                       : 16'($urandom_range(1, 64));
                end
            endcase
            set_config(ph_ch, ph_ang, ph_fl);
            runs_left = 80000 / run_cost();
            if (runs_left > 12) runs_left = 12;
            for (int k = 0; k < 60 && items_sent < TOTAL_ITEMS; k++)
            begin
                pick = int'($urandom_range(0, 9));
                if (pick < 6 && runs_left > 0)
                begin
                    // reload part of the run bin, then a whole matrix
                    if ($urandom_range(0, 1))
                    begin
                        it = rand_item(OP_WEIGHT);
                        it.bin = RUN_BIN;
                        it.angle = 5'($urandom_range(0, sb.eff_angles() - 1));
                        send_item(it);
                        it = rand_item(OP_STEER);
                        it.bin = RUN_BIN;
                        send_item(it);
                    end
                    send_matrix(RUN_BIN, ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                         : 32'($urandom_range(0, 1 << 22)));
                    runs_left--;
                end
                else
                begin
                    // noise: any load, a lone element, or an ignored opcode
                    it = rand_item(opcode_t'($urandom_range(0, 2)));
                    if (pick == 9)
                        it.opcode = 2'd3;
                    send_item(it);
                end
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
